### hdl/cfr_pkg.sv
`default_nettype none

package cfr_pkg;

  localparam int unsigned ODOM_FRAME_LEN   = 26;
  localparam int unsigned SENSOR_FRAME_LEN = 28;
  localparam int unsigned FRAME_MAX =
      (ODOM_FRAME_LEN > SENSOR_FRAME_LEN) ? ODOM_FRAME_LEN : SENSOR_FRAME_LEN;
  localparam int unsigned IDX_W = $clog2(FRAME_MAX);
  localparam int unsigned CNT_W = $clog2(FRAME_MAX + 1);

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned FCNT_W     = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] HDR_FIRST  = 8'hFF;
  localparam logic [7:0] HDR_ODOM   = 8'hFE;
  localparam logic [7:0] HDR_SENSOR = 8'hFF;

  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_TIMEOUT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CSUM    = 2'd1,
    ST_HEADER  = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_e;

  typedef enum logic {
    FT_ODOM   = 1'b0,
    FT_SENSOR = 1'b1
  } frame_type_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HEAD = 2'd1,
    PH_BODY = 2'd2
  } phase_e;

  typedef logic [FRAME_MAX-1:0][7:0] frame_t;

  typedef struct packed {
    status_e     status;
    frame_type_e ftype;
    frame_t      data;
  } job_t;

endpackage

`default_nettype wire

### hdl/chassis_frame_receiver.sv
`default_nettype none

// Receives UART bytes and timeout events and one item is accepted per clock
// cycle whenever the two-entry job queue between the parser and the result
// stage has room. A frame that ends, or fails, pushes one job holding the
// whole frame; the result stage then gives one result per cycle while
// out_ready_i is high: a single result for an odometry frame or an error,
// and a run of 28 results for a good sensor frame. Input stalls only when
// both queue entries are taken while the result stage is still busy with a run or held by out_ready_i.
module chassis_frame_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic        frame_type_o,
  output logic [7:0]  raw_byte_o,
  output logic        last_o,
  output logic [31:0] left_wheel_count_o,
  output logic [31:0] right_wheel_count_o,
  output logic [15:0] yaw_value_o,
  output logic [15:0] roll_value_o,
  output logic [15:0] pitch_value_o,
  output logic [15:0] accel_x_o,
  output logic [15:0] accel_y_o,
  output logic [15:0] accel_z_o
);
  import cfr_pkg::*;

  logic space;
  logic push;
  job_t push_job;
  logic pop;
  logic job_valid;
  job_t pop_job;

  cfr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .rx_byte_i  (rx_byte_i),
    .space_i    (space),
    .push_o     (push),
    .job_o      (push_job)
  );

  cfr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .space_o     (space),
    .pop_i       (pop),
    .valid_o     (job_valid),
    .pop_data_o  (pop_job)
  );

  cfr_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .job_valid_i         (job_valid),
    .job_i               (pop_job),
    .pop_o               (pop),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .status_o            (status_o),
    .frame_type_o        (frame_type_o),
    .raw_byte_o          (raw_byte_o),
    .last_o              (last_o),
    .left_wheel_count_o  (left_wheel_count_o),
    .right_wheel_count_o (right_wheel_count_o),
    .yaw_value_o         (yaw_value_o),
    .roll_value_o        (roll_value_o),
    .pitch_value_o       (pitch_value_o),
    .accel_x_o           (accel_x_o),
    .accel_y_o           (accel_y_o),
    .accel_z_o           (accel_z_o)
  );

endmodule

`default_nettype wire

### hdl/cfr_front.sv
`default_nettype none

module cfr_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          kind_i,
  input  logic [7:0]    rx_byte_i,
  input  logic          space_i,
  output logic          push_o,
  output cfr_pkg::job_t job_o
);
  import cfr_pkg::*;

  phase_e                phase_q, phase_d;
  frame_type_e           kind_q, kind_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [7:0]            sum_q, sum_d;
  frame_t                store_q;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_idx;
  logic                  accept;
  logic                  timeout;
  logic [CNT_W-1:0]      len;
  frame_t                snap;

  assign in_ready_o = space_i;
  assign accept     = in_valid_i & space_i;
  assign timeout    = (kind_i == KIND_TIMEOUT);
  assign len        = (kind_q == FT_SENSOR) ? CNT_W'(SENSOR_FRAME_LEN)
                                            : CNT_W'(ODOM_FRAME_LEN);

  always_comb begin
    for (int i = 0; i < FRAME_MAX; i++) begin
      snap[i] = (IDX_W'(i) == cnt_q[IDX_W-1:0]) ? rx_byte_i : store_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      kind_q  <= FT_ODOM;
      cnt_q   <= '0;
      sum_q   <= '0;
    end else begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_idx] <= rx_byte_i;
    end
  end

  always_comb begin
    phase_d      = phase_q;
    kind_d       = kind_q;
    cnt_d        = cnt_q;
    sum_d        = sum_q;
    wr_en        = 1'b0;
    wr_idx       = cnt_q[IDX_W-1:0];
    push_o       = 1'b0;
    job_o.status = ST_OK;
    job_o.ftype  = FT_ODOM;
    job_o.data   = snap;
    if (accept) begin
      unique case (phase_q)
        PH_HEAD: begin
          if (timeout) begin
            push_o       = 1'b1;
            job_o.status = ST_TIMEOUT;
            phase_d      = PH_IDLE;
          end else if (rx_byte_i == HDR_ODOM || rx_byte_i == HDR_SENSOR) begin
            kind_d  = (rx_byte_i == HDR_SENSOR) ? FT_SENSOR : FT_ODOM;
            wr_en   = 1'b1;
            wr_idx  = IDX_W'(1);
            sum_d   = sum_q + rx_byte_i;
            cnt_d   = CNT_W'(2);
            phase_d = PH_BODY;
          end else begin
            push_o       = 1'b1;
            job_o.status = ST_HEADER;
            phase_d      = PH_IDLE;
          end
        end
        PH_BODY: begin
          job_o.ftype = kind_q;
          if (timeout) begin
            push_o       = 1'b1;
            job_o.status = ST_TIMEOUT;
            phase_d      = PH_IDLE;
          end else if ((cnt_q + CNT_W'(1)) < len) begin
            wr_en = 1'b1;
            sum_d = sum_q + rx_byte_i;
            cnt_d = cnt_q + CNT_W'(1);
          end else begin
            push_o       = 1'b1;
            job_o.status = (sum_q == rx_byte_i) ? ST_OK : ST_CSUM;
            phase_d      = PH_IDLE;
          end
        end
        default: begin
          if (!timeout && rx_byte_i == HDR_FIRST) begin
            wr_en   = 1'b1;
            wr_idx  = '0;
            sum_d   = rx_byte_i;
            cnt_d   = CNT_W'(1);
            kind_d  = FT_ODOM;
            phase_d = PH_HEAD;
          end else begin
            phase_d = PH_IDLE;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/cfr_fifo.sv
`default_nettype none

module cfr_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cfr_pkg::job_t push_data_i,
  output logic          space_o,
  input  logic          pop_i,
  output logic          valid_o,
  output cfr_pkg::job_t pop_data_o
);
  import cfr_pkg::*;

  job_t              mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FCNT_W-1:0] count_q;

  assign space_o    = (count_q != FCNT_W'(FIFO_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + FCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - FCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

### hdl/cfr_back.sv
`default_nettype none

module cfr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  cfr_pkg::job_t job_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [1:0]    status_o,
  output logic          frame_type_o,
  output logic [7:0]    raw_byte_o,
  output logic          last_o,
  output logic [31:0]   left_wheel_count_o,
  output logic [31:0]   right_wheel_count_o,
  output logic [15:0]   yaw_value_o,
  output logic [15:0]   roll_value_o,
  output logic [15:0]   pitch_value_o,
  output logic [15:0]   accel_x_o,
  output logic [15:0]   accel_y_o,
  output logic [15:0]   accel_z_o
);
  import cfr_pkg::*;

  job_t             job_q;
  logic             valid_q;
  logic [IDX_W-1:0] idx_q;
  logic             is_run;
  logic             is_odom;
  logic             done;

  assign is_run  = (job_q.status == ST_OK) && (job_q.ftype == FT_SENSOR);
  assign is_odom = (job_q.status == ST_OK) && (job_q.ftype == FT_ODOM);
  assign last_o  = !is_run || (idx_q == IDX_W'(SENSOR_FRAME_LEN - 1));
  assign done    = valid_q && out_ready_i && last_o;
  assign pop_o   = job_valid_i && (!valid_q || done);

  assign out_valid_o  = valid_q;
  assign status_o     = job_q.status;
  assign frame_type_o = job_q.ftype;
  assign raw_byte_o   = is_run ? job_q.data[idx_q] : 8'd0;

  assign left_wheel_count_o  = is_odom ? {job_q.data[5], job_q.data[4],
                                          job_q.data[3], job_q.data[2]} : '0;
  assign right_wheel_count_o = is_odom ? {job_q.data[9], job_q.data[8],
                                          job_q.data[7], job_q.data[6]} : '0;
  assign yaw_value_o   = is_odom ? {job_q.data[11], job_q.data[10]} : '0;
  assign roll_value_o  = is_odom ? {job_q.data[13], job_q.data[12]} : '0;
  assign pitch_value_o = is_odom ? {job_q.data[15], job_q.data[14]} : '0;
  assign accel_x_o     = is_odom ? {job_q.data[17], job_q.data[16]} : '0;
  assign accel_y_o     = is_odom ? {job_q.data[19], job_q.data[18]} : '0;
  assign accel_z_o     = is_odom ? {job_q.data[21], job_q.data[20]} : '0;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (valid_q && out_ready_i) begin
      if (last_o) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + IDX_W'(1);
      end
    end
  end

endmodule

`default_nettype wire
